### design/cpu16_integer_alu_with_flags_defines.svh
// Assertion macros shared by the ALU checker.
// Depends on nothing; included by the checker file only.
`ifndef CPU16_INTEGER_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU16_INTEGER_ALU_WITH_FLAGS_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ALU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alu check failed");
// Next-cycle implication checked outside reset.
`define ALU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alu check failed");
`endif

### design/c16alu_pkg.sv
// Package for the 16-bit ALU: operation codes, state encodings and bus structs.
// Depends on nothing.
`default_nettype none
package c16alu_pkg;
    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_OR = 5'd1, OP_ADC = 5'd2, OP_SBB = 5'd3, OP_AND = 5'd4,
        OP_SUB = 5'd5, OP_XOR = 5'd6, OP_CMP = 5'd7, OP_TEST = 5'd8, OP_INC = 5'd9,
        OP_DEC = 5'd10, OP_NOT = 5'd11, OP_NEG = 5'd12, OP_MUL = 5'd13,
        OP_IMUL = 5'd14, OP_DIV = 5'd15, OP_IDIV = 5'd16
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SIMPLE, ST_MUL, ST_DIV_LOAD, ST_DIV_STEP, ST_DIV_FIN, ST_OUT
    } t_state;

    localparam int DivSteps = 32;

    typedef struct packed {
        logic [4:0]  operation;
        logic        wide;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [15:0] operand_high;
    } t_in;

    typedef struct packed {
        logic [15:0] result_low;
        logic [15:0] result_high;
        logic        high_valid;
        logic        write_result;
        logic        carry_flag;
        logic        overflow_flag;
        logic        sign_flag;
        logic        zero_flag;
        logic        aux_carry_flag;
        logic        parity_flag;
        logic        divide_error;
    } t_out;

    typedef struct packed {
        logic load;      // capture the input item
        logic simple;    // finish an operation other than multiply or divide
        logic mul;       // finish a multiply
        logic div_init;  // set up the divider
        logic div_step;  // one quotient bit
        logic div_fin;   // fix signs and range, finish the divide
    } t_cmd;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
    } t_stat;
endpackage
`default_nettype wire

### design/c16alu_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface c16alu_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/c16alu_ctrl.sv
// Controller state machine of the ALU: sequences load, execute, divide and output.
// Depends on c16alu_pkg.
`default_nettype none
module c16alu_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    input  wire c16alu_pkg::t_stat   i_stat,
    output c16alu_pkg::t_cmd         o_cmd
);
    import c16alu_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_SIMPLE;
                end
            end
            ST_SIMPLE: begin
                if (i_stat.is_mul) n_state = ST_MUL;
                else if (i_stat.is_div) n_state = ST_DIV_LOAD;
                else begin
                    o_cmd.simple = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ST_OUT;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_init = 1'b1;
                n_state = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = ST_DIV_FIN;
            end
            ST_DIV_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                // Take the next item in the same cycle the result leaves.
                if (i_out_ready) begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = ST_SIMPLE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### design/c16alu_dp.sv
// Datapath of the ALU: operand registers, adder/logic unit, multiplier,
// bit-serial divider and flag register. Depends on c16alu_pkg.
`default_nettype none
module c16alu_dp (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire c16alu_pkg::t_in     i_item,
    input  wire c16alu_pkg::t_cmd    i_cmd,
    output c16alu_pkg::t_stat        o_stat,
    output c16alu_pkg::t_out         o_res
);
    import c16alu_pkg::*;

    t_in         r_in;
    logic [5:0]  r_flags;          // {PF, AF, ZF, SF, OF, CF}
    t_out        r_res, n_res;
    logic [15:0] r_rem;            // partial remainder; the dividend shifts out of r_quo
    logic [31:0] r_quo;
    logic [15:0] r_dvs;
    logic        r_neg_q, r_neg_r, r_derr;
    logic [5:0]  r_cnt;

    // Operand views.
    logic [15:0] mask, sgn, a, b;
    logic        cin;
    assign mask = r_in.wide ? 16'hFFFF : 16'h00FF;
    assign sgn  = r_in.wide ? 16'h8000 : 16'h0080;
    assign a    = r_in.operand_a & mask;
    assign b    = r_in.operand_b & mask;
    assign cin  = r_flags[0];

    assign o_stat.is_mul   = (r_in.operation == OP_MUL) || (r_in.operation == OP_IMUL);
    assign o_stat.is_div   = (r_in.operation == OP_DIV) || (r_in.operation == OP_IDIV);
    assign o_stat.div_last = (r_cnt == 6'(DivSteps - 1));
    assign o_res = r_res;

    function automatic logic [2:0] szp(input logic [15:0] r, input logic [15:0] m,
                                       input logic [15:0] s);
        logic [2:0] f;
        begin
            f[0] = |(r & s);
            f[1] = ((r & m) == 16'h0);
            f[2] = ~^r[7:0];
            return f; // {PF, ZF, SF}
        end
    endfunction

    // Operations other than multiply and divide.
    logic [16:0] sum;
    logic [15:0] opx, opy;
    logic        is_sub, use_arith, keep_cf;
    logic [5:0]  f_simple;
    logic [15:0] lo_simple;
    logic        wr_simple;
    logic [2:0]  zs;
    logic        cf, of, af;

    always_comb begin
        opx = a; opy = b; is_sub = 1'b0; use_arith = 1'b1; keep_cf = 1'b0;
        wr_simple = 1'b1; lo_simple = '0; sum = '0;
        case (r_in.operation)
            OP_ADD: sum = {1'b0, a} + {1'b0, b};
            OP_ADC: sum = {1'b0, a} + {1'b0, b} + {16'h0, cin};
            OP_SBB: begin sum = {1'b0, a} - {1'b0, b} - {16'h0, cin}; is_sub = 1'b1; end
            OP_SUB: begin sum = {1'b0, a} - {1'b0, b}; is_sub = 1'b1; end
            OP_CMP: begin
                sum = {1'b0, a} - {1'b0, b}; is_sub = 1'b1; wr_simple = 1'b0;
            end
            OP_INC: begin opy = 16'h1; sum = {1'b0, a} + 17'h1; keep_cf = 1'b1; end
            OP_DEC: begin
                opy = 16'h1; sum = {1'b0, a} - 17'h1; is_sub = 1'b1; keep_cf = 1'b1;
            end
            OP_NEG: begin opx = '0; opy = a; sum = 17'h0 - {1'b0, a}; is_sub = 1'b1; end
            OP_OR:  begin use_arith = 1'b0; sum = {1'b0, a | b}; end
            OP_AND: begin use_arith = 1'b0; sum = {1'b0, a & b}; end
            OP_XOR: begin use_arith = 1'b0; sum = {1'b0, a ^ b}; end
            OP_TEST: begin use_arith = 1'b0; sum = {1'b0, a & b}; wr_simple = 1'b0; end
            OP_NOT: begin use_arith = 1'b0; sum = {1'b0, ~a}; end
            default: begin use_arith = 1'b0; wr_simple = 1'b0; end
        endcase
        lo_simple = sum[15:0] & mask;
        zs = szp(sum[15:0], mask, sgn);
        // Carry or borrow out of the active width.
        cf = r_in.wide ? sum[16] : sum[8];
        of = is_sub ? |((opx ^ opy) & (opx ^ sum[15:0]) & sgn)
                    : |((sum[15:0] ^ opx) & (sum[15:0] ^ opy) & sgn);
        af = opx[4] ^ opy[4] ^ sum[4];
        if (use_arith)
            f_simple = {zs[2], af, zs[1], zs[0], of, keep_cf ? cin : cf};
        else if (r_in.operation == OP_OR || r_in.operation == OP_AND ||
                 r_in.operation == OP_XOR || r_in.operation == OP_TEST)
            f_simple = {zs[2], 1'b0, zs[1], zs[0], 1'b0, 1'b0};
        else
            f_simple = r_flags;
    end

    // Multiplier: sign-adjusted 17x17 product, combinational from the captured operands.
    logic signed [16:0] ma, mb;
    logic signed [33:0] mp;
    logic               mbig;
    always_comb begin
        if (r_in.operation == OP_IMUL) begin
            ma = r_in.wide ? {a[15], a} : {{9{a[7]}}, a[7:0]};
            mb = r_in.wide ? {b[15], b} : {{9{b[7]}}, b[7:0]};
        end else begin
            ma = {1'b0, a};
            mb = {1'b0, b};
        end
        mp = ma * mb;
        if (r_in.operation == OP_IMUL)
            mbig = r_in.wide ? (mp[31:15] != {17{mp[15]}})
                             : (mp[15:7] != {9{mp[7]}});
        else
            mbig = r_in.wide ? (mp[31:16] != 16'h0) : (mp[15:8] != 8'h0);
    end

    // Divider operand magnitudes.
    logic        sdiv, dvd_neg, dvs_neg;
    logic [31:0] dvd_raw, dvd_mag;
    logic [15:0] dvs_raw, dvs_mag;
    always_comb begin
        sdiv = (r_in.operation == OP_IDIV);
        dvd_raw = r_in.wide ? {r_in.operand_high, r_in.operand_a}
                            : {{16{r_in.operand_a[15]}}, r_in.operand_a};
        dvs_raw = r_in.wide ? b : {{8{b[7]}}, b[7:0]};
        dvd_neg = sdiv & dvd_raw[31];
        dvs_neg = sdiv & dvs_raw[15];
        if (!sdiv) begin
            dvd_raw = r_in.wide ? {r_in.operand_high, r_in.operand_a}
                                : {16'h0, r_in.operand_a};
            dvs_raw = b;
        end
        dvd_mag = dvd_neg ? (32'h0 - dvd_raw) : dvd_raw;
        dvs_mag = dvs_neg ? (16'h0 - dvs_raw) : dvs_raw;
    end

    // One restoring-division step.
    logic [16:0] trial_rem;
    logic [16:0] diff;
    assign trial_rem = {r_rem, r_quo[31]};
    assign diff = trial_rem - {1'b0, r_dvs};

    // Final divide result.
    logic [31:0] q_s;
    logic [15:0] rm_s;
    logic        q_ovf;
    always_comb begin
        q_s  = r_neg_q ? (32'h0 - r_quo) : r_quo;
        rm_s = r_neg_r ? (16'h0 - r_rem) : r_rem;
        if (!sdiv)
            q_ovf = r_in.wide ? (r_quo[31:16] != 16'h0) : (r_quo[31:8] != 24'h0);
        else if (r_in.wide)
            q_ovf = r_neg_q ? (r_quo > 32'h8000) : (r_quo > 32'h7FFF);
        else
            q_ovf = r_neg_q ? (r_quo > 32'h80) : (r_quo > 32'h7F);
    end

    // Next result item.
    always_comb begin
        n_res = r_res;
        if (i_cmd.simple) begin
            n_res = '0;
            n_res.result_low = lo_simple;
            n_res.write_result = wr_simple;
            {n_res.parity_flag, n_res.aux_carry_flag, n_res.zero_flag,
             n_res.sign_flag, n_res.overflow_flag, n_res.carry_flag} = f_simple;
        end
        if (i_cmd.mul) begin
            n_res = '0;
            n_res.result_low = mp[15:0] & mask;
            n_res.result_high = (r_in.wide ? mp[31:16] : {8'h0, mp[15:8]});
            n_res.high_valid = 1'b1;
            n_res.write_result = 1'b1;
            {n_res.parity_flag, n_res.aux_carry_flag, n_res.zero_flag,
             n_res.sign_flag, n_res.overflow_flag, n_res.carry_flag}
                = {r_flags[5:2], mbig, mbig};
        end
        if (i_cmd.div_fin) begin
            n_res = '0;
            {n_res.parity_flag, n_res.aux_carry_flag, n_res.zero_flag,
             n_res.sign_flag, n_res.overflow_flag, n_res.carry_flag} = r_flags;
            if (r_derr || q_ovf) begin
                n_res.divide_error = 1'b1;
            end else begin
                n_res.result_low = q_s[15:0] & mask;
                n_res.result_high = rm_s & mask;
                n_res.high_valid = 1'b1;
                n_res.write_result = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_flags <= '0;
        else if (i_cmd.simple) r_flags <= f_simple;
        else if (i_cmd.mul) r_flags <= {r_flags[5:2], mbig, mbig};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_item;
        r_res <= n_res;
        if (i_cmd.div_init) begin
            r_quo   <= dvd_mag;
            r_rem   <= '0;
            r_dvs   <= dvs_mag;
            r_neg_q <= dvd_neg ^ dvs_neg;
            r_neg_r <= dvd_neg;
            r_derr  <= (b == 16'h0);
            r_cnt   <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 6'd1;
            if (!diff[16]) begin
                r_rem <= diff[15:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial_rem[15:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

### design/cpu16_integer_alu_with_flags.sv
// Top level of the 16-bit x86-style ALU with flags.
// Depends on c16alu_pkg, c16alu_if, c16alu_ctrl and c16alu_dp.
//
//  Channel   Direction  Payload
//  in_ch     sink       operation, wide, operand_a, operand_b, operand_high
//  out_ch    source     result words, high_valid, write_result, flags, divide_error
//
// Non-multiply, non-divide results are registered in ST_SIMPLE, shown in ST_OUT;
// MUL and IMUL go on to ST_MUL, which registers the 17x17 multiplier product.
// DIV and IDIV: the restoring divider retires one quotient bit per cycle.
// The next item is accepted in the cycle the result is taken.
// Reset clears the flags and the controller; a stalled result holds.
`default_nettype none
module cpu16_integer_alu_with_flags (
    input wire i_clk,
    input wire i_rst_n,
    c16alu_if.sink   in_ch,
    c16alu_if.source out_ch
);
    import c16alu_pkg::*;
    t_cmd  cmd;
    t_stat stat;

    c16alu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    c16alu_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(in_ch.data), .i_cmd(cmd), .o_stat(stat), .o_res(out_ch.data)
    );
endmodule
`default_nettype wire

### design/c16alu_checker.sv
// Port-level checker for the ALU, bound to the top level.
// Depends on c16alu_pkg and the defines header.
`default_nettype none
`include "cpu16_integer_alu_with_flags_defines.svh"
module c16alu_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire c16alu_pkg::t_out i_out
);
    import c16alu_pkg::*;
    `ALU_ASSERT_IMP(a_derr_nowrite, i_clk, i_rst_n, i_out_valid && i_out.divide_error, !i_out.write_result && !i_out.high_valid)
    `ALU_ASSERT_IMP(a_hi_zero, i_clk, i_rst_n, i_out_valid && !i_out.high_valid, i_out.result_high == 16'h0)
    `ALU_ASSERT_NXT(a_accept_gap, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_out_valid && !i_in_ready)
    `ALU_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out))
endmodule

bind cpu16_integer_alu_with_flags c16alu_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
    .i_out(out_ch.data)
);
`default_nettype wire

### dv/tb_cpu16_integer_alu_with_flags_sb.sv
// Flag-tracking predictor and result checker for the 16-bit ALU testbench.
// Depends on c16alu_pkg.
`timescale 1ns / 1ps
import c16alu_pkg::*;

class alu_scoreboard;
    logic [5:0] flags;      // bit0 CF, 1 OF, 2 SF, 3 ZF, 4 AF, 5 PF
    t_out       pending[$];
    int         errors;

    function new();
        flags = '0;
        errors = 0;
    endfunction

    function automatic logic [5:0] szp(int unsigned r, int unsigned mask, int unsigned sgn);
        logic [5:0] f;
        f = '0;
        f[2] = (r & sgn) != 0;
        f[3] = (r & mask) == 0;
        f[5] = ~(^r[7:0]);
        return f;
    endfunction

    function automatic logic [5:0] arith(int unsigned a, int unsigned b, int unsigned r,
                                          bit sub, int unsigned mask, int unsigned sgn);
        logic [5:0] f;
        f = szp(r, mask, sgn);
        f[0] = (r & ~mask) != 0;
        if (sub)
            f[1] = ((a ^ b) & (a ^ r) & sgn) != 0;
        else
            f[1] = ((r ^ a) & (r ^ b) & sgn) != 0;
        f[4] = ((a ^ b ^ r) & 32'h10) != 0;
        return f;
    endfunction

    // Computes the result of one accepted item and queues it.
    function void note_item(t_in it);
        int unsigned mask, sgn, a, b, a16, cin, lo, hi, r, dvd;
        longint sd, sv, q, rm, p;
        bit hv, wr, derr;
        logic [5:0] f;
        t_out o;
        mask = it.wide ? 32'hFFFF : 32'hFF;
        sgn = it.wide ? 32'h8000 : 32'h80;
        a16 = it.operand_a;
        a = a16 & mask;
        b = it.operand_b & mask;
        cin = flags[0];
        f = flags;
        lo = 0; hi = 0; hv = 0; wr = 1; derr = 0;
        case (it.operation)
            OP_ADD: begin r = a + b; f = arith(a, b, r, 0, mask, sgn); lo = r; end
            OP_ADC: begin r = a + b + cin; f = arith(a, b, r, 0, mask, sgn); lo = r; end
            OP_SBB: begin r = a - b - cin; f = arith(a, b, r, 1, mask, sgn); lo = r; end
            OP_SUB: begin r = a - b; f = arith(a, b, r, 1, mask, sgn); lo = r; end
            OP_CMP: begin
                r = a - b; f = arith(a, b, r, 1, mask, sgn); lo = r; wr = 0;
            end
            OP_OR:  begin lo = a | b; f = szp(lo, mask, sgn); end
            OP_AND: begin lo = a & b; f = szp(lo, mask, sgn); end
            OP_XOR: begin lo = a ^ b; f = szp(lo, mask, sgn); end
            OP_TEST: begin lo = a & b; f = szp(lo, mask, sgn); wr = 0; end
            OP_INC: begin
                r = a + 1; f = arith(a, 1, r, 0, mask, sgn); f[0] = cin[0]; lo = r;
            end
            OP_DEC: begin
                r = a - 1; f = arith(a, 1, r, 1, mask, sgn); f[0] = cin[0]; lo = r;
            end
            OP_NOT: lo = ~a;
            OP_NEG: begin r = 0 - a; f = arith(0, a, r, 1, mask, sgn); lo = r; end
            OP_MUL: begin
                r = a * b; lo = r; hi = it.wide ? r >> 16 : r >> 8; hv = 1;
                f[0] = it.wide ? (r >> 16) != 0 : (r >> 8) != 0; f[1] = f[0];
            end
            OP_IMUL: begin
                if (it.wide) begin
                    p = longint'($signed(a[15:0])) * longint'($signed(b[15:0]));
                    f[0] = p > 32'sh7FFF || p < -32'sh8000;
                    lo = p; hi = int'(p) >>> 16;
                end else begin
                    p = longint'($signed(a[7:0])) * longint'($signed(b[7:0]));
                    f[0] = p > 127 || p < -128;
                    lo = p; hi = int'(p) >>> 8;
                end
                f[1] = f[0]; hv = 1;
            end
            OP_DIV: begin
                dvd = it.wide ? {it.operand_high, it.operand_a} : a16;
                if (b == 0 || dvd / b > mask) derr = 1;
                else begin lo = dvd / b; hi = dvd % b; hv = 1; end
            end
            OP_IDIV: begin
                if (b == 0) derr = 1;
                else begin
                    if (it.wide) begin
                        sd = longint'($signed({it.operand_high, it.operand_a}));
                        sv = longint'($signed(b[15:0]));
                    end else begin
                        sd = longint'($signed(a16[15:0]));
                        sv = longint'($signed(b[7:0]));
                    end
                    q = sd / sv;
                    rm = sd % sv;
                    if (it.wide ? (q > 32767 || q < -32768) : (q > 127 || q < -128))
                        derr = 1;
                    else begin lo = q; hi = rm; hv = 1; end
                end
            end
            default: wr = 0;
        endcase
        if (derr) begin lo = 0; hi = 0; hv = 0; wr = 0; end
        flags = f;
        o.result_low = lo & mask;
        o.result_high = hv ? (hi & mask) : 0;
        o.high_valid = hv;
        o.write_result = wr;
        o.carry_flag = f[0];
        o.overflow_flag = f[1];
        o.sign_flag = f[2];
        o.zero_flag = f[3];
        o.aux_carry_flag = f[4];
        o.parity_flag = f[5];
        o.divide_error = derr;
        pending.push_back(o);
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endfunction

    function void check_result(t_out got);
        t_out w;
        if (pending.size() == 0) begin
            $display("mismatch: result with no item outstanding");
            errors++;
            return;
        end
        w = pending.pop_front();
        if (got.result_low !== w.result_low) report("result_low", got.result_low, w.result_low);
        if (got.result_high !== w.result_high)
            report("result_high", got.result_high, w.result_high);
        if (got.high_valid !== w.high_valid) report("high_valid", got.high_valid, w.high_valid);
        if (got.write_result !== w.write_result)
            report("write_result", got.write_result, w.write_result);
        if (got.carry_flag !== w.carry_flag) report("carry_flag", got.carry_flag, w.carry_flag);
        if (got.overflow_flag !== w.overflow_flag)
            report("overflow_flag", got.overflow_flag, w.overflow_flag);
        if (got.sign_flag !== w.sign_flag) report("sign_flag", got.sign_flag, w.sign_flag);
        if (got.zero_flag !== w.zero_flag) report("zero_flag", got.zero_flag, w.zero_flag);
        if (got.aux_carry_flag !== w.aux_carry_flag)
            report("aux_carry_flag", got.aux_carry_flag, w.aux_carry_flag);
        if (got.parity_flag !== w.parity_flag)
            report("parity_flag", got.parity_flag, w.parity_flag);
        if (got.divide_error !== w.divide_error)
            report("divide_error", got.divide_error, w.divide_error);
    endfunction
endclass

### dv/tb_cpu16_integer_alu_with_flags.sv
// Top of the ALU testbench: directed and random items under varying idle patterns.
// Depends on c16alu_pkg, c16alu_if, the DUT and tb_cpu16_integer_alu_with_flags_sb.sv.
`timescale 1ns / 1ps
import c16alu_pkg::*;

module tb_cpu16_integer_alu_with_flags;
    localparam int WatchdogLimit = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;
    alu_scoreboard sb = new();

    c16alu_if #(.T(t_in))  in_ch ();
    c16alu_if #(.T(t_out)) out_ch ();

    cpu16_integer_alu_with_flags dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
    end

    // Monitor and watchdog; everything is sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver stalls at random, changing at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Valid stays high into the next item; idle cycles and drains drop it.
    task automatic send_item(t_in it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_fields(t_op op, bit w, logic [15:0] a, logic [15:0] b,
                               logic [15:0] h);
        t_in it;
        it.operation = op; it.wide = w; it.operand_a = a; it.operand_b = b;
        it.operand_high = h;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {8'h00, 8'($urandom_range(255))};
            3: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int count);
        t_in it;
        for (int i = 0; i < count; i++) begin
            it.operation = ($urandom_range(19) == 0) ? 5'($urandom_range(31))
                                                    : 5'($urandom_range(OP_IDIV));
            it.wide = 1'($urandom_range(1));
            it.operand_a = pick16();
            it.operand_b = pick16();
            it.operand_high = pick16();
            // Keep most divides in range so that quotients are exercised.
            if ((it.operation == OP_DIV || it.operation == OP_IDIV) && $urandom_range(3) != 0)
                begin
                if (it.wide) it.operand_high = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
                else it.operand_a = 16'($urandom_range(255));
                if (it.operand_b == 0) it.operand_b = 16'h7F35;
            end
            send_item(it);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: extremes, every operation, flag carry chains, divide errors.
        send_fields(OP_ADD, 0, 16'h00FF, 16'h0001, 0);
        send_fields(OP_ADC, 0, 16'h007F, 16'h0000, 0);
        send_fields(OP_ADD, 1, 16'hFFFF, 16'hFFFF, 0);
        send_fields(OP_SBB, 1, 16'h8000, 16'h0001, 0);
        send_fields(OP_SUB, 0, 16'h0000, 16'h0001, 0);
        send_fields(OP_SBB, 0, 16'h0080, 16'h0000, 0);
        send_fields(OP_OR, 1, 16'h0000, 16'h0000, 0);
        send_fields(OP_AND, 1, 16'hFFFF, 16'h8000, 0);
        send_fields(OP_XOR, 0, 16'hFFAA, 16'h0055, 0);
        send_fields(OP_CMP, 1, 16'h7FFF, 16'hFFFF, 0);
        send_fields(OP_TEST, 0, 16'h00F0, 16'h000F, 0);
        send_fields(OP_INC, 0, 16'h007F, 0, 0);
        send_fields(OP_DEC, 1, 16'h8000, 0, 0);
        send_fields(OP_NOT, 1, 16'h1234, 0, 0);
        send_fields(OP_NEG, 1, 16'h8000, 0, 0);
        send_fields(OP_NEG, 0, 16'h0000, 0, 0);
        send_fields(OP_MUL, 1, 16'hFFFF, 16'hFFFF, 0);
        send_fields(OP_MUL, 0, 16'h0010, 16'h0008, 0);
        send_fields(OP_IMUL, 0, 16'h0080, 16'h00FF, 0);
        send_fields(OP_IMUL, 1, 16'h8000, 16'hFFFF, 0);
        send_fields(OP_DIV, 1, 16'h1234, 16'h0000, 16'h0001);
        send_fields(OP_DIV, 0, 16'hFFFF, 16'h00FF, 0);
        send_fields(OP_IDIV, 0, 16'h8000, 16'h00FF, 0);
        send_fields(OP_IDIV, 1, 16'hFFF9, 16'h0002, 16'hFFFF);
        send_fields(t_op'(5'd31), 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        random_items(250);
        send_idle_pct = 80;
        random_items(250);
        wait_drained();    // sender holds off until every result is back
        send_idle_pct = 0;
        recv_stall_pct = 80;
        random_items(250);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        random_items(250);

        wait_drained();
        recv_stall_pct = 0;
        repeat (60) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
